[hdl/mwmu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmu_pkg
// Shared types and constants for the maze wall map update block.
// ----------------------------------------------------------------------------
package mwmu_pkg;

  localparam int GRID_SIDE = 16;
  localparam int COORD_W   = 4;
  localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int WALL_W    = 4;
  localparam int IR_W      = 10;
  localparam int DIST_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [IR_W-1:0]   SIDE_THR_RST  = IR_W'(500);
  localparam logic [DIST_W-1:0] FRONT_THR_RST = DIST_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_THR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_THR = 1'd1;

  localparam logic [WALL_W-1:0] WALL_N = 4'b0001;
  localparam logic [WALL_W-1:0] WALL_E = 4'b0010;
  localparam logic [WALL_W-1:0] WALL_S = 4'b0100;
  localparam logic [WALL_W-1:0] WALL_WEST = 4'b1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR,
    ST_NB_RD,
    ST_NB_WR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WALL_W-1:0] wr_data;
  } mem_req_t;

  function automatic logic [WALL_W-1:0] rot_left(input logic [WALL_W-1:0] v,
                                                 input logic [1:0] r);
    logic [2*WALL_W-1:0] d;
    d = {v, v} << r;
    return d[2*WALL_W-1:WALL_W];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return ADDR_W'(y) * ADDR_W'(GRID_SIDE) + ADDR_W'(x);
  endfunction

endpackage

[hdl/maze_wall_map_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_wall_map_update_top
// Steps: the accepted item is registered, the current cell is written back with
// its new walls, then each neighbor cell that shares a new wall (up to 3) is
// read and written; an item outside the grid goes straight to the result. One
// item at a time, set by the read-modify-write of the wall RAM: the next item
// is accepted only after the last result is registered; a stalled result holds it off.
// Reset: all cell entries read as zero at once (per-entry valid flags),
// thresholds return to 500 and 100 mm.
// ----------------------------------------------------------------------------
module maze_wall_map_update_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mwmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwmu_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mwmu_pkg::COORD_W-1:0]    in_cell_x,
  input  logic [mwmu_pkg::COORD_W-1:0]    in_cell_y,
  input  logic [1:0]                      in_heading,
  input  logic [mwmu_pkg::DIST_W-1:0]     in_front_distance_mm,
  input  logic [mwmu_pkg::IR_W-1:0]       in_left_ir,
  input  logic [mwmu_pkg::IR_W-1:0]       in_right_ir,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_wall_discovered,
  output logic [mwmu_pkg::WALL_W-1:0]     out_cell_walls
);
  import mwmu_pkg::*;

  mem_req_t          mem_req;
  logic [WALL_W-1:0] mem_rd_data;

  mwmu_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cell_x            (in_cell_x),
    .in_cell_y            (in_cell_y),
    .in_heading           (in_heading),
    .in_front_distance_mm (in_front_distance_mm),
    .in_left_ir           (in_left_ir),
    .in_right_ir          (in_right_ir),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_wall_discovered  (out_wall_discovered),
    .out_cell_walls       (out_cell_walls),
    .mem_req              (mem_req),
    .mem_rd_data          (mem_rd_data)
  );

  mwmu_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

[hdl/mwmu_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmu_store
// Wall store: one synchronous RAM entry per cell plus a valid flag per entry.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module mwmu_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwmu_pkg::mem_req_t            req,
  output logic [mwmu_pkg::WALL_W-1:0]   rd_data
);
  import mwmu_pkg::*;

  logic [WALL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [WALL_W-1:0] q_r;
  logic              q_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        q_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

[hdl/mwmu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmu_ctrl
// Sensor decode, threshold registers and the read-modify-write sequencer for
// the current cell and its neighbors.
// ----------------------------------------------------------------------------
module mwmu_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mwmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwmu_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mwmu_pkg::COORD_W-1:0]    in_cell_x,
  input  logic [mwmu_pkg::COORD_W-1:0]    in_cell_y,
  input  logic [1:0]                      in_heading,
  input  logic [mwmu_pkg::DIST_W-1:0]     in_front_distance_mm,
  input  logic [mwmu_pkg::IR_W-1:0]       in_left_ir,
  input  logic [mwmu_pkg::IR_W-1:0]       in_right_ir,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_wall_discovered,
  output logic [mwmu_pkg::WALL_W-1:0]     out_cell_walls,
  output mwmu_pkg::mem_req_t              mem_req,
  input  logic [mwmu_pkg::WALL_W-1:0]     mem_rd_data
);
  import mwmu_pkg::*;

  state_t state_r, state_nxt;

  logic [IR_W-1:0]    side_thr_r;
  logic [DIST_W-1:0]  front_thr_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [ADDR_W-1:0]  addr_r, nb_addr_r;
  logic [WALL_W-1:0]  absw_r, walls_r, pend_r, sel_r;
  logic               found_r;
  logic               out_valid_r, out_found_r;
  logic [WALL_W-1:0]  out_walls_r;

  logic              in_acc, in_range, out_free;
  logic [WALL_W-1:0] rel, absw_in, exist, cur_new, cur_nb, pend_left, sel_nxt;
  logic [ADDR_W-1:0] nb_addr_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign in_range = (32'(in_cell_x) < GRID_SIDE) && (32'(in_cell_y) < GRID_SIDE);
  assign out_free = !out_valid_r || !out_stall;

  assign rel = {(in_left_ir > side_thr_r), 1'b0, (in_right_ir > side_thr_r),
                (in_front_distance_mm <= front_thr_r)};
  assign absw_in = rot_left(rel, in_heading);

  assign exist = {(x_r != '0), (32'(y_r) + 1 < GRID_SIDE),
                  (32'(x_r) + 1 < GRID_SIDE), (y_r != '0)};
  assign cur_new   = absw_r & ~mem_rd_data;
  assign cur_nb    = cur_new & exist;
  assign pend_left = pend_r & ~sel_r;
  assign sel_nxt   = pend_r & (~pend_r + WALL_W'(1));

  always_comb begin
    nb_addr_nxt = addr_r;
    unique case (sel_nxt)
      WALL_N:    nb_addr_nxt = addr_r - ADDR_W'(GRID_SIDE);
      WALL_S:    nb_addr_nxt = addr_r + ADDR_W'(GRID_SIDE);
      WALL_E:    nb_addr_nxt = addr_r + ADDR_W'(1);
      WALL_WEST: nb_addr_nxt = addr_r - ADDR_W'(1);
      default:   nb_addr_nxt = addr_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = in_range ? ST_CUR : ST_FIN;
      ST_CUR:   state_nxt = (|cur_nb) ? ST_NB_RD : ST_FIN;
      ST_NB_RD: state_nxt = ST_NB_WR;
      ST_NB_WR: state_nxt = (|pend_left) ? ST_NB_RD : ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mem_req  = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall        = 1'b0;
        mem_req.rd_en   = in_valid && in_range;
        mem_req.rd_addr = cell_addr(in_cell_x, in_cell_y);
      end
      ST_CUR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = addr_r;
        mem_req.wr_data = mem_rd_data | absw_r;
      end
      ST_NB_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = nb_addr_nxt;
      end
      ST_NB_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = nb_addr_r;
        mem_req.wr_data = mem_rd_data | rot_left(sel_r, 2'd2);
      end
      ST_FIN: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_wall_discovered = out_found_r;
  assign out_cell_walls      = out_walls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_thr_r  <= SIDE_THR_RST;
      front_thr_r <= FRONT_THR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIDE_THR:  side_thr_r  <= cfg_wdata[IR_W-1:0];
          CFG_FRONT_THR: front_thr_r <= cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      x_r     <= in_cell_x;
      y_r     <= in_cell_y;
      addr_r  <= cell_addr(in_cell_x, in_cell_y);
      absw_r  <= absw_in;
      walls_r <= '0;
      found_r <= 1'b0;
    end
    if (state_r == ST_CUR) begin
      walls_r <= mem_rd_data | absw_r;
      found_r <= |cur_new;
      pend_r  <= cur_nb;
    end
    if (state_r == ST_NB_RD) begin
      sel_r     <= sel_nxt;
      nb_addr_r <= nb_addr_nxt;
    end
    if (state_r == ST_NB_WR) begin
      pend_r <= pend_left;
    end
    if (state_r == ST_FIN && out_free) begin
      out_found_r <= found_r;
      out_walls_r <= walls_r;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the maze wall map update block. Sensor sweeps go in
// through a directed table, then through five threshold settings of random
// sweeps; the first four settings favor one band of rows each. A local copy
// of the wall map predicts each result the table does not give, and results
// are checked in order. Both sides idle in random bursts except at the tail.
// ----------------------------------------------------------------------------
module tb_top;
  import mwmu_pkg::*;

  typedef enum logic [1:0] {
    HEAD_NORTH,
    HEAD_EAST,
    HEAD_SOUTH,
    HEAD_WEST
  } heading_t;

  localparam logic [DIST_W-1:0] DIST_TIMEOUT = 16'd9999;
  localparam int DRAIN_CYCLES  = 16;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASES        = 5;
  localparam int PHASE_SWEEPS  = 350;
  localparam int QUIET_FROM    = 100;
  localparam int PRINT_CAP     = 50;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         heading;
    logic [DIST_W-1:0]  dist_mm;
    logic [IR_W-1:0]    left_ir;
    logic [IR_W-1:0]    right_ir;
  } sweep_t;

  typedef struct {
    logic              found;
    logic [WALL_W-1:0] walls;
  } walls_result_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   data;
    sweep_t                 sw;
    bit                     typed;
    walls_result_t          want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [COORD_W-1:0]     in_cell_x = '0;
  logic [COORD_W-1:0]     in_cell_y = '0;
  logic [1:0]             in_heading = '0;
  logic [DIST_W-1:0]      in_front_distance_mm = '0;
  logic [IR_W-1:0]        in_left_ir = '0;
  logic [IR_W-1:0]        in_right_ir = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_wall_discovered;
  logic [WALL_W-1:0]      out_cell_walls;

  maze_wall_map_update_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cell_x            (in_cell_x),
    .in_cell_y            (in_cell_y),
    .in_heading           (in_heading),
    .in_front_distance_mm (in_front_distance_mm),
    .in_left_ir           (in_left_ir),
    .in_right_ir          (in_right_ir),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_wall_discovered  (out_wall_discovered),
    .out_cell_walls       (out_cell_walls)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted map and thresholds
  logic [WALL_W-1:0] wall_map [DEPTH];
  logic [IR_W-1:0]   side_thr  = SIDE_THR_RST;
  logic [DIST_W-1:0] front_thr = FRONT_THR_RST;

  walls_result_t pending_walls [$];
  walls_result_t got_walls;

  int  err_cnt      = 0;
  int  sweeps_sent  = 0;
  int  results_seen = 0;
  int  new_wall_cnt = 0;
  int  cfg_writes   = 0;
  int  idle_cycles  = 0;
  bit  quiet        = 1'b0;
  int  stall_run    = 0;
  bit  stall_on     = 1'b0;

  initial begin
    for (int i = 0; i < DEPTH; i++) wall_map[i] = '0;
  end

  task automatic report(input string what);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic set_wall(input int x, input int y, input logic [WALL_W-1:0] wbit,
                          inout logic found);
    int idx;
    idx = y * GRID_SIDE + x;
    if ((wall_map[idx] & wbit) != '0) return;
    wall_map[idx] = wall_map[idx] | wbit;
    found = 1'b1;
    case (wbit)
      WALL_N: begin
        if (y > 0) wall_map[idx - GRID_SIDE] = wall_map[idx - GRID_SIDE] | WALL_S;
      end
      WALL_S: begin
        if (y + 1 < GRID_SIDE) wall_map[idx + GRID_SIDE] = wall_map[idx + GRID_SIDE] | WALL_N;
      end
      WALL_WEST: begin
        if (x > 0) wall_map[idx - 1] = wall_map[idx - 1] | WALL_E;
      end
      default: begin
        if (x + 1 < GRID_SIDE) wall_map[idx + 1] = wall_map[idx + 1] | WALL_WEST;
      end
    endcase
  endtask

  task automatic predict_sweep(input sweep_t s, output walls_result_t r);
    logic [WALL_W-1:0] rel;
    logic [WALL_W-1:0] absw;
    logic              found;
    int                x;
    int                y;
    x = int'(s.x);
    y = int'(s.y);
    r.found = 1'b0;
    r.walls = '0;
    if (x >= GRID_SIDE || y >= GRID_SIDE) return;
    rel = '0;
    if (s.dist_mm <= front_thr) rel = rel | WALL_N;
    if (s.right_ir > side_thr)  rel = rel | WALL_E;
    if (s.left_ir > side_thr)   rel = rel | WALL_WEST;
    // one quarter turn clockwise per heading step
    absw = rel;
    for (int k = 0; k < int'(s.heading); k++) absw = {absw[WALL_W-2:0], absw[WALL_W-1]};
    found = 1'b0;
    if ((absw & WALL_N) != '0)    set_wall(x, y, WALL_N, found);
    if ((absw & WALL_S) != '0)    set_wall(x, y, WALL_S, found);
    if ((absw & WALL_WEST) != '0) set_wall(x, y, WALL_WEST, found);
    if ((absw & WALL_E) != '0)    set_wall(x, y, WALL_E, found);
    r.found = found;
    r.walls = wall_map[y * GRID_SIDE + x];
  endtask

  task automatic send_sweep(input sweep_t s, input bit typed, input walls_result_t want);
    walls_result_t pred;
    in_valid             <= 1'b1;
    in_cell_x            <= s.x;
    in_cell_y            <= s.y;
    in_heading           <= s.heading;
    in_front_distance_mm <= s.dist_mm;
    in_left_ir           <= s.left_ir;
    in_right_ir          <= s.right_ir;
    do @(posedge clk); while (in_stall);
    predict_sweep(s, pred);
    if (typed) pending_walls.push_back(want);
    else pending_walls.push_back(pred);
    sweeps_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_walls.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SIDE_THR) side_thr = data[IR_W-1:0];
    else front_thr = data;
    cfg_writes++;
  endtask

  task automatic input_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [IR_W-1:0] pick_ir();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return side_thr;
    if (r < 10) return side_thr + 1'b1;
    if (r < 20) return IR_W'($urandom);
    if (r < 32 && side_thr != '1) return IR_W'($urandom_range(int'(side_thr) + 1, 1023));
    return IR_W'($urandom_range(0, int'(side_thr)));
  endfunction

  function automatic logic [DIST_W-1:0] pick_dist();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return front_thr;
    if (r < 10) return front_thr + 1'b1;
    if (r < 16) return DIST_TIMEOUT;
    if (r < 26) return DIST_W'($urandom);
    if (r < 38) return DIST_W'($urandom_range(0, int'(front_thr)));
    if (front_thr != '1) return DIST_W'($urandom_range(int'(front_thr) + 1, 65535));
    return DIST_W'($urandom);
  endfunction

  // in the first four phases, most sweeps land in the phase's own band of four rows
  task automatic make_sweep(input int band, output sweep_t s);
    s.x = COORD_W'($urandom_range(0, GRID_SIDE - 1));
    if (band < 4 && $urandom_range(0, 4) != 0)
      s.y = COORD_W'(band * 4 + $urandom_range(0, 3));
    else
      s.y = COORD_W'($urandom_range(0, GRID_SIDE - 1));
    s.heading  = 2'($urandom_range(0, 3));
    s.dist_mm  = pick_dist();
    s.left_ir  = pick_ir();
    s.right_ir = pick_ir();
  endtask

  function automatic dir_row_t sweep_row(input int x, input int y, input heading_t h,
                                         input int d, input int l, input int r,
                                         input bit typed, input bit f, input int w);
    dir_row_t row;
    row.is_cfg      = 1'b0;
    row.idx         = '0;
    row.data        = '0;
    row.sw.x        = COORD_W'(x);
    row.sw.y        = COORD_W'(y);
    row.sw.heading  = h;
    row.sw.dist_mm  = DIST_W'(d);
    row.sw.left_ir  = IR_W'(l);
    row.sw.right_ir = IR_W'(r);
    row.typed       = typed;
    row.want.found  = f;
    row.want.walls  = WALL_W'(w);
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DAT_W-1:0] data);
    dir_row_t row;
    row        = sweep_row(0, 0, HEAD_NORTH, 0, 0, 0, 1'b0, 1'b0, 0);
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_wall_discovered === 1'b1) new_wall_cnt++;
      if (pending_walls.size() == 0) begin
        report($sformatf("unexpected result found=%b walls=%h",
                         out_wall_discovered, out_cell_walls));
      end else begin
        got_walls = pending_walls.pop_front();
        if (out_wall_discovered !== got_walls.found)
          report($sformatf("result %0d wall_discovered %b, want %b", results_seen,
                           out_wall_discovered, got_walls.found));
        if (out_cell_walls !== got_walls.walls)
          report($sformatf("result %0d cell_walls %h, want %h", results_seen,
                           out_cell_walls, got_walls.walls));
      end
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_run == 0) begin
      stall_on  = ($urandom_range(0, 2) == 0);
      stall_run = stall_on ? $urandom_range(1, 10) : $urandom_range(1, 25);
      out_stall <= stall_on;
    end else begin
      stall_run--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t          rows [$];
    sweep_t            s;
    walls_result_t     no_want;
    logic [CFG_DAT_W-1:0] side_set  [PHASES];
    logic [CFG_DAT_W-1:0] front_set [PHASES];

    no_want.found = 1'b0;
    no_want.walls = '0;

    // reset thresholds 500 / 100 apply to the first rows
    rows.push_back(sweep_row(0, 0, HEAD_NORTH, 100, 501, 500, 1'b1, 1'b1, 9));
    rows.push_back(sweep_row(0, 0, HEAD_NORTH, 100, 501, 500, 1'b1, 1'b0, 9));
    rows.push_back(sweep_row(15, 15, HEAD_SOUTH, 0, 1023, 1023, 1'b1, 1'b1, 14));
    rows.push_back(sweep_row(14, 15, HEAD_EAST, 101, 0, 0, 1'b1, 1'b0, 2));
    rows.push_back(sweep_row(15, 0, HEAD_WEST, 65535, 1023, 0, 1'b1, 1'b1, 4));
    rows.push_back(sweep_row(7, 7, HEAD_NORTH, 9999, 0, 0, 1'b1, 1'b0, 0));
    // timeout distance counts once the front threshold reaches it
    rows.push_back(cfg_row(CFG_FRONT_THR, DIST_TIMEOUT));
    rows.push_back(sweep_row(7, 7, HEAD_EAST, 9999, 0, 0, 1'b1, 1'b1, 2));
    rows.push_back(sweep_row(8, 7, HEAD_SOUTH, 10000, 700, 200, 1'b0, 1'b0, 0));
    rows.push_back(cfg_row(CFG_SIDE_THR, 16'h0000));
    rows.push_back(sweep_row(3, 5, HEAD_NORTH, 65535, 0, 1, 1'b1, 1'b1, 2));
    rows.push_back(cfg_row(CFG_SIDE_THR, 16'h03FF));
    rows.push_back(sweep_row(3, 5, HEAD_SOUTH, 65535, 1023, 1023, 1'b1, 1'b0, 2));
    rows.push_back(cfg_row(CFG_FRONT_THR, 16'h0000));
    rows.push_back(sweep_row(3, 6, HEAD_NORTH, 0, 0, 0, 1'b1, 1'b1, 1));
    rows.push_back(sweep_row(3, 5, HEAD_WEST, 1, 1023, 1023, 1'b1, 1'b0, 6));
    rows.push_back(cfg_row(CFG_FRONT_THR, 16'hFFFF));
    rows.push_back(sweep_row(10, 3, HEAD_WEST, 65535, 0, 0, 1'b1, 1'b1, 8));
    // upper data bits beyond the side threshold width are dropped
    rows.push_back(cfg_row(CFG_SIDE_THR, 16'hFC05));
    rows.push_back(sweep_row(10, 3, HEAD_WEST, 0, 6, 5, 1'b0, 1'b0, 0));
    rows.push_back(sweep_row(9, 3, HEAD_EAST, 12345, 5, 1023, 1'b0, 1'b0, 0));

    side_set[0]  = 16'd37;
    front_set[0] = DIST_TIMEOUT;
    side_set[1]  = 16'h03FF;
    front_set[1] = 16'h0000;
    side_set[2]  = CFG_DAT_W'($urandom);
    front_set[2] = CFG_DAT_W'($urandom);
    side_set[3]  = 16'hFC00;
    front_set[3] = 16'hFFFF;
    side_set[4]  = 16'd500;
    front_set[4] = 16'd100;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        input_gap();
        send_sweep(rows[i].sw, rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_SIDE_THR, side_set[ph]);
      write_reg(CFG_FRONT_THR, front_set[ph]);
      for (int i = 0; i < PHASE_SWEEPS; i++) begin
        if (ph == PHASES - 1 && i >= QUIET_FROM) quiet = 1'b1;
        input_gap();
        make_sweep(ph, s);
        send_sweep(s, 1'b0, no_want);
      end
    end

    in_valid <= 1'b0;
    while (pending_walls.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sweeps and %0d checked results, %0d of them with new walls",
             sweeps_sent, results_seen, new_wall_cnt);
    $display("threshold writes: %0d over %0d settings, %0d errors", cfg_writes, PHASES,
             err_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
